/* src/pbcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcc_pkg: shared types and constants of the push-button click classifier
// Event codes, state encodings, timer sizing and the run entry that carries
// the events of one tick from the classifier to the output stage.
// ----------------------------------------------------------------------------
package pbcc_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_BUTTON_INDEX = 2'd0,
        CFG_DEBOUNCE     = 2'd1,
        CFG_DOUBLE_CLICK = 2'd2,
        CFG_LONG_CLICK   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_POWERON = 3'd0,
        EV_SHORT   = 3'd1,
        EV_UNDO    = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_UP     = 2'd0,
        ST_DOWN   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_LONG   = 2'd3
    } t_click_state;

    typedef enum logic [1:0] {
        TM_IDLE     = 2'd0,
        TM_DEBOUNCE = 2'd1,
        TM_LONG     = 2'd2
    } t_timer_mode;

    // Events caused by one tick: one or two of them.
    typedef struct packed {
        t_event code0;
        t_event code1;
        logic   two;
        logic   button_id;
    } t_run;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] double_click_ticks;
        logic [CFG_W-1:0] long_click_ticks;
    } t_timing;

    // Register values above the timer range load as the timer maximum.
    function automatic logic [TIMER_W-1:0] clamp_ticks(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve > CMP_W'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return TIMER_W'(ve);
    endfunction

endpackage

/* src/pbcc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcc_front: debounce and click classification
// Takes one pin sample per accepted tick, runs the debounce / long-press
// timer and the click state, and hands each tick's events on as one run.
// ----------------------------------------------------------------------------
module pbcc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_pin_level,
    input  logic            i_button_id,
    input  pbcc_pkg::t_timing i_timing,
    output logic            o_run_push,
    output pbcc_pkg::t_run  o_run
);
    import pbcc_pkg::*;

    t_click_state       r_click, n_click;
    t_timer_mode        r_mode, n_mode;
    logic [TIMER_W-1:0] r_count, n_count;
    logic [TIMER_W-1:0] r_age, n_age;
    logic               r_prev, n_prev;
    logic               r_started, n_started;
    logic [TIMER_W-1:0] age_inc;
    logic               in_window;

    assign age_inc   = (r_age != TIMER_MAX) ? r_age + TIMER_W'(1) : r_age;
    assign in_window = (age_inc != TIMER_MAX) &&
                       (CMP_W'(age_inc) < CMP_W'(i_timing.double_click_ticks));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click   <= ST_UP;
            r_mode    <= TM_IDLE;
            r_count   <= '0;
            r_age     <= TIMER_MAX;
            r_prev    <= 1'b1;
            r_started <= 1'b0;
        end else begin
            r_click   <= n_click;
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_age     <= n_age;
            r_prev    <= n_prev;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_click   = r_click;
        n_mode    = r_mode;
        n_count   = r_count;
        n_age     = r_age;
        n_prev    = r_prev;
        n_started = r_started;
        o_run_push      = 1'b0;
        o_run.code0     = EV_POWERON;
        o_run.code1     = EV_DOUBLE;
        o_run.two       = 1'b0;
        o_run.button_id = i_button_id;
        if (i_accept) begin
            if (!r_started) begin
                // first tick: power-on check only, no debounce
                n_started = 1'b1;
                n_prev    = i_pin_level;
                if (!i_pin_level) begin
                    o_run_push = 1'b1;
                end
            end else begin
                n_age = age_inc;
                if (i_pin_level != r_prev) begin
                    n_prev  = i_pin_level;
                    n_mode  = TM_DEBOUNCE;
                    n_count = clamp_ticks(i_timing.debounce_ticks);
                end else if (r_mode != TM_IDLE) begin
                    if (r_count > TIMER_W'(1)) begin
                        n_count = r_count - TIMER_W'(1);
                    end else begin
                        n_mode  = TM_IDLE;
                        n_count = '0;
                        if (r_mode == TM_LONG) begin
                            o_run_push  = 1'b1;
                            o_run.code0 = EV_LONG;
                            n_click     = ST_LONG;
                        end else if (i_pin_level) begin
                            n_age = '0;
                            if (r_click == ST_DOWN) begin
                                o_run_push  = 1'b1;
                                o_run.code0 = EV_SHORT;
                            end
                            n_click = ST_UP;
                        end else if (in_window) begin
                            o_run_push  = 1'b1;
                            o_run.code0 = EV_UNDO;
                            o_run.two   = 1'b1;
                            n_click     = ST_DOUBLE;
                        end else begin
                            n_click = ST_DOWN;
                            n_mode  = TM_LONG;
                            n_count = clamp_ticks(i_timing.long_click_ticks);
                        end
                    end
                end
            end
        end
    end

endmodule

/* src/pbcc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcc_queue: run queue between classifier and output stage
// Small first-in first-out store of runs; head entry visible while not empty.
// ----------------------------------------------------------------------------
module pbcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbcc_pkg::t_run i_data,
    input  logic           i_pop,
    output pbcc_pkg::t_run o_data,
    output logic           o_full,
    output logic           o_empty
);
    import pbcc_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* src/pbcc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcc_back: output stage
// Pulls runs from the queue and presents their events one at a time,
// flagging the last event of each run.
// ----------------------------------------------------------------------------
module pbcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbcc_pkg::t_run i_run,
    input  logic           i_run_empty,
    output logic           o_run_pop,
    input  logic           pop,
    output logic           empty,
    output logic           o_event_valid,
    output logic [2:0]     o_event_code,
    output logic           o_button_id,
    output logic           o_last_of_run
);
    import pbcc_pkg::*;

    logic r_valid;
    logic r_second;
    t_run r_run;
    logic take;
    logic load;

    assign take = r_valid && pop;
    // reload once the held run is used up or nothing is held
    assign load = !r_valid || (take && (!r_run.two || r_second));
    assign o_run_pop = load && !i_run_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= !i_run_empty;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_run_pop) begin
            r_run <= i_run;
        end
    end

    assign empty         = !r_valid;
    assign o_event_valid = r_valid;
    assign o_event_code  = r_second ? r_run.code1 : r_run.code0;
    assign o_button_id   = r_run.button_id;
    assign o_last_of_run = !r_run.two || r_second;

endmodule

/* src/push_button_click_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_button_click_classifier: debounced click event detector
// Turns one sampled button level per tick into power-on, short, undo,
// double and long click events.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive i_pin_level with push; a tick is taken when
//   push is high and full is low. One tick can be taken every cycle.
//   Output side is a queue: while empty is low the oldest event is on the
//   o_* ports; pop takes it. A tick yields zero, one or two events; the
//   last event of a tick has o_last_of_run set.
//   An event reaches the o_* ports once its run is in the output register:
//   the classifier writes the run queue as the tick is taken, and the output
//   register loads from the queue whenever it is free.
//   Throughput: one tick per cycle in while full is low, one event per
//   cycle out while pop is high; two-event runs leave one event at a time.
//   A stalled receiver fills the four-entry run queue; full then rises and
//   ticks are held off. Ticks that cause no event never fill it.
//   Reset (synchronous, active low) restores register defaults (index 0,
//   debounce 20, double click 300, long click 1000) and empties the queue.
//   Configuration: i_cfg_wr_en, i_cfg_idx, i_cfg_data; write only while idle.
// ----------------------------------------------------------------------------
module push_button_click_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [pbcc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_pin_level,
    input  logic                       pop,
    output logic                       empty,
    output logic                       o_event_valid,
    output logic [2:0]                 o_event_code,
    output logic                       o_button_id,
    output logic                       o_last_of_run
);
    import pbcc_pkg::*;

    logic    r_button_index;
    t_timing r_timing;
    logic    accept;
    logic    run_push;
    t_run    run_in;
    t_run    run_head;
    logic    run_pop;
    logic    run_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_index              <= 1'b0;
            r_timing.debounce_ticks     <= CFG_W'(20);
            r_timing.double_click_ticks <= CFG_W'(300);
            r_timing.long_click_ticks   <= CFG_W'(1000);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BUTTON_INDEX: r_button_index              <= i_cfg_data[0];
                CFG_DEBOUNCE:     r_timing.debounce_ticks     <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_timing.double_click_ticks <= i_cfg_data;
                CFG_LONG_CLICK:   r_timing.long_click_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    pbcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_button_id (r_button_index),
        .i_timing    (r_timing),
        .o_run_push  (run_push),
        .o_run       (run_in)
    );

    pbcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (run_push),
        .i_data  (run_in),
        .i_pop   (run_pop),
        .o_data  (run_head),
        .o_full  (full),
        .o_empty (run_empty)
    );

    pbcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (run_head),
        .i_run_empty   (run_empty),
        .o_run_pop     (run_pop),
        .pop           (pop),
        .empty         (empty),
        .o_event_valid (o_event_valid),
        .o_event_code  (o_event_code),
        .o_button_id   (o_button_id),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: push-button click classifier
// Feeds sampled button levels through the tick queue and checks every click
// event that comes out against a cycle-free model of the debounce, double
// click and long press logic. A short table of hand-made ticks comes first,
// then random press and release episodes under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import pbcc_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE = 8;          // pipeline is two deep; margin on top
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        t_event code;
        logic   id;
        logic   last;
    } click_ev_t;

    typedef enum {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        t_cfg_idx         reg_idx;
        logic [CFG_W-1:0] data;
        logic             lvl;
        bit               typed;     // expected events given in the row
        int               n;
        t_event           c0;
        t_event           c1;
    } dir_row_t;

    typedef struct {
        logic             idx;
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] dbl;
        logic [CFG_W-1:0] lng;
        int               n_ticks;
        bit               quiet;     // no idling on either side
        bit               squeeze;   // receiver holds off for a long stretch
    } phase_t;

    localparam int N_DIR = 24;
    localparam int N_PHASES = 7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [1:0]           i_cfg_idx = CFG_BUTTON_INDEX;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_pin_level = 1'b1;
    logic                 pop = 1'b0;
    logic                 empty;
    logic                 o_event_valid;
    logic [2:0]           o_event_code;
    logic                 o_button_id;
    logic                 o_last_of_run;

    push_button_click_classifier uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_pin_level   (i_pin_level),
        .pop           (pop),
        .empty         (empty),
        .o_event_valid (o_event_valid),
        .o_event_code  (o_event_code),
        .o_button_id   (o_button_id),
        .o_last_of_run (o_last_of_run)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Register copies, at their reset values
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_deb = 16'd20;
    logic [CFG_W-1:0] cfg_dbl = 16'd300;
    logic [CFG_W-1:0] cfg_long = 16'd1000;

    // Classifier state
    t_click_state       btn_state = ST_UP;
    t_timer_mode        tmr_mode = TM_IDLE;
    logic [TIMER_W-1:0] tmr_count = '0;
    logic [TIMER_W-1:0] rel_age = TIMER_MAX;
    logic               prev_lvl = 1'b1;
    bit                 seen_first = 1'b0;

    click_ev_t tick_events[$];     // events of the tick just classified
    click_ev_t pending_clicks[$];  // events still owed by the block
    logic      tick_plan[$];

    int  errors = 0;
    int  cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    click_ev_t rx_want;

    dir_row_t dir_rows [N_DIR] = '{
        // power-on with the line low, then held low: no press yet
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b1, 1, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b1, 0, EV_POWERON, EV_POWERON},
        // zero debounce and long press act as one tick
        '{ROW_CFG,  CFG_BUTTON_INDEX, 16'd1, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_CFG,  CFG_DEBOUNCE,     16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_CFG,  CFG_DOUBLE_CLICK, 16'd4, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_CFG,  CFG_LONG_CLICK,   16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        // glitch high, then a press before any release: long click, no double
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        // release after long click: no short click
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        // quick press after release: undo then double
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        // wait out the double click window
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        // press, then release cancels the long press: short click
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b0, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON},
        '{ROW_TICK, CFG_BUTTON_INDEX, 16'd0, 1'b1, 1'b0, 0, EV_POWERON, EV_POWERON}
    };

    phase_t phases [N_PHASES] = '{
        '{1'b0, 16'd3,     16'd12,    16'd20,    400, 1'b0, 1'b0},
        '{1'b1, 16'd1,     16'hFFFF,  16'd8,     300, 1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd0,     16'd0,     300, 1'b0, 1'b1},
        '{1'b1, 16'd2,     16'd5,     16'hFFFF,  250, 1'b0, 1'b0},
        '{1'b1, 16'hFFFF,  16'hFFFF,  16'd1,     80,  1'b0, 1'b0},
        '{1'b0, 16'd1,     16'd2,     16'd1,     300, 1'b1, 1'b0},
        '{1'b1, 16'd5,     16'd40,    16'd25,    270, 1'b0, 1'b0}
    };

    task automatic report(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        end
    endtask

    function automatic void add_event(input t_event code);
        tick_events.push_back('{code, cfg_index, 1'b0});
    endfunction

    // One tick of the classifier; fills tick_events
    function automatic void classify_tick(input logic lvl);
        t_timer_mode mode;
        tick_events.delete();
        if (!seen_first) begin
            seen_first = 1'b1;
            prev_lvl = lvl;
            if (!lvl) begin
                add_event(EV_POWERON);
            end
        end else begin
            if (rel_age != TIMER_MAX) begin
                rel_age++;
            end
            if (lvl != prev_lvl) begin
                prev_lvl = lvl;
                tmr_mode = TM_DEBOUNCE;
                tmr_count = TIMER_W'(cfg_deb);
            end else if (tmr_mode != TM_IDLE) begin
                if (tmr_count > 1) begin
                    tmr_count--;
                end else begin
                    mode = tmr_mode;
                    tmr_mode = TM_IDLE;
                    tmr_count = '0;
                    if (mode == TM_LONG) begin
                        add_event(EV_LONG);
                        btn_state = ST_LONG;
                    end else if (lvl) begin
                        rel_age = '0;
                        if (btn_state == ST_DOWN) begin
                            add_event(EV_SHORT);
                        end
                        btn_state = ST_UP;
                    end else begin
                        btn_state = ST_DOWN;
                        if (rel_age != TIMER_MAX && rel_age < cfg_dbl) begin
                            add_event(EV_UNDO);
                            add_event(EV_DOUBLE);
                            btn_state = ST_DOUBLE;
                        end else begin
                            tmr_mode = TM_LONG;
                            tmr_count = TIMER_W'(cfg_long);
                        end
                    end
                end
            end
        end
        if (tick_events.size() > 0) begin
            tick_events[tick_events.size() - 1].last = 1'b1;
        end
    endfunction

    // Offer one tick request and wait for it to be taken
    task automatic send_tick(input logic lvl, input bit keep);
        while (tx_idle_on && $urandom_range(0, 99) < 32) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (full);
        classify_tick(lvl);
        if (keep) begin
            foreach (tick_events[k]) pending_clicks.push_back(tick_events[k]);
        end
    endtask

    // Stop offering, let every owed event out, then let the pipeline settle
    task automatic drain();
        push <= 1'b0;
        while (pending_clicks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx r, input logic [CFG_W-1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (r)
            CFG_BUTTON_INDEX: cfg_index = v[0];
            CFG_DEBOUNCE:     cfg_deb = v;
            CFG_DOUBLE_CLICK: cfg_dbl = v;
            CFG_LONG_CLICK:   cfg_long = v;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic int span_of(input logic [CFG_W-1:0] v, input int cap);
        return (v == 0) ? 1 : ((v > cap) ? cap : int'(v));
    endfunction

    function automatic void add_bounce();
        repeat ($urandom_range(1, 3)) tick_plan.push_back(1'($urandom_range(0, 1)));
    endfunction

    // One press/release episode, or at times a burst of random levels; hold times picked around the register values
    function automatic void plan_episode();
        int d;
        int dw;
        int lw;
        int n;
        d = span_of(cfg_deb, 40);
        dw = span_of(cfg_dbl, 40);
        lw = span_of(cfg_long, 40);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) tick_plan.push_back(1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 2) == 0) add_bounce();
        case ($urandom_range(0, 2))
            0: n = $urandom_range(1, d);
            1: n = $urandom_range(d + 1, d + lw + 1);
            default: n = $urandom_range(d + lw + 2, d + lw + 12);
        endcase
        repeat (n) tick_plan.push_back(1'b0);
        if ($urandom_range(0, 2) == 0) add_bounce();
        case ($urandom_range(0, 2))
            0: n = $urandom_range(1, d);
            1: n = $urandom_range(d + 1, d + dw + 1);
            default: n = $urandom_range(d + dw + 2, d + dw + 16);
        endcase
        repeat (n) tick_plan.push_back(1'b1);
    endfunction

    // Receiver: checks each popped event, idles at random or on a hold request
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (pending_clicks.size() == 0) begin
                report("event with none owed, code", o_event_code, 0);
            end else begin
                rx_want = pending_clicks.pop_front();
                if (o_event_valid !== 1'b1) report("event_valid", o_event_valid, 1);
                if (o_event_code !== rx_want.code) report("event_code", o_event_code, rx_want.code);
                if (o_button_id !== rx_want.id) report("button_id", o_button_id, rx_want.id);
                if (o_last_of_run !== rx_want.last) report("last_of_run", o_last_of_run, rx_want.last);
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= !(rx_idle_on && $urandom_range(0, 99) < 32);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[push_button_click_classifier] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].reg_idx, dir_rows[r].data);
            end else if (dir_rows[r].typed) begin
                send_tick(dir_rows[r].lvl, 1'b0);
                for (int k = 0; k < dir_rows[r].n; k++) begin
                    pending_clicks.push_back('{(k == 0) ? dir_rows[r].c0 : dir_rows[r].c1,
                                               cfg_index, k == dir_rows[r].n - 1});
                end
            end else begin
                send_tick(dir_rows[r].lvl, 1'b1);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_BUTTON_INDEX, {{(CFG_W-1){1'b0}}, phases[p].idx});
            write_reg(CFG_DEBOUNCE, phases[p].deb);
            write_reg(CFG_DOUBLE_CLICK, phases[p].dbl);
            write_reg(CFG_LONG_CLICK, phases[p].lng);
            tx_idle_on = !phases[p].quiet;
            rx_idle_on = !phases[p].quiet;
            // receiver stalls while ticks keep coming: the run queue fills up
            if (phases[p].squeeze) hold_reqs++;
            tick_plan.delete();
            while (tick_plan.size() < phases[p].n_ticks) plan_episode();
            while (tick_plan.size() != 0) send_tick(tick_plan.pop_front(), 1'b1);
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain();
        if (errors == 0) begin
            $display("[push_button_click_classifier] OK");
        end else begin
            $display("[push_button_click_classifier] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/pbcc_pkg.sv
src/pbcc_front.sv
src/pbcc_queue.sv
src/pbcc_back.sv
src/push_button_click_classifier.sv
sim/testbench.sv
